FILE: design/simple_risc_decode_execute_defines.svh
// Assertion helpers used by the top-level RTL file.
`ifndef SIMPLE_RISC_DECODE_EXECUTE_DEFINES_SVH
`define SIMPLE_RISC_DECODE_EXECUTE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SRDE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define SRDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/srde_pkg.sv
package srde_pkg;

  localparam int DATA_MEM_DEPTH_DEF = 4096;
  localparam int PC_WIDTH_DEF       = 12;

  localparam int XLEN        = 32;
  localparam int REG_IDX_W   = 4;
  localparam int NEXT_PC_W   = 12;
  localparam int MEM_ADDR_W  = 12;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 88;

  localparam logic [1:0] REQ_EXEC   = 2'd0;
  localparam logic [1:0] REQ_MEM_WR = 2'd1;
  localparam logic [1:0] REQ_MEM_RD = 2'd2;

  localparam logic [7:0] OP_ADD  = 8'd0;
  localparam logic [7:0] OP_SUB  = 8'd1;
  localparam logic [7:0] OP_AND  = 8'd2;
  localparam logic [7:0] OP_OR   = 8'd3;
  localparam logic [7:0] OP_XOR  = 8'd4;
  localparam logic [7:0] OP_MUL  = 8'd5;
  localparam logic [7:0] OP_SLL  = 8'd6;
  localparam logic [7:0] OP_SRA  = 8'd7;
  localparam logic [7:0] OP_SRL  = 8'd8;
  localparam logic [7:0] OP_BEQ  = 8'd9;
  localparam logic [7:0] OP_BNE  = 8'd10;
  localparam logic [7:0] OP_BLT  = 8'd11;
  localparam logic [7:0] OP_BGT  = 8'd12;
  localparam logic [7:0] OP_BLE  = 8'd13;
  localparam logic [7:0] OP_BGE  = 8'd14;
  localparam logic [7:0] OP_JAL  = 8'd15;
  localparam logic [7:0] OP_LW   = 8'd16;
  localparam logic [7:0] OP_SW   = 8'd17;
  localparam logic [7:0] OP_LL   = 8'd18;
  localparam logic [7:0] OP_SC   = 8'd19;
  localparam logic [7:0] OP_HALT = 8'd20;

  localparam logic [REG_IDX_W-1:0] REG_ZERO    = 4'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMM     = 4'd1;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_GP = 4'd2;
  localparam logic [REG_IDX_W-1:0] REG_LINK    = 4'd15;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [XLEN-1:0]       instruction;
    logic [MEM_ADDR_W-1:0] mem_addr;
    logic [XLEN-1:0]       mem_data;
  } in_item_t;

  typedef struct packed {
    logic                 valid;
    logic [REG_IDX_W-1:0] idx;
    logic [XLEN-1:0]      data;
  } reg_wr_t;

  typedef struct packed {
    logic                 halted;
    logic                 nop;
    logic                 rw;
    logic [REG_IDX_W-1:0] ridx;
    logic [XLEN-1:0]      rval;
    logic                 is_load;
    logic                 dm_we;
    logic                 dm_re;
    logic                 rdback;
    logic [XLEN-1:0]      dm_addr;
    logic [XLEN-1:0]      dm_wdata;
  } ex_ctl_t;

  typedef struct packed {
    logic                 nop;
    logic                 rw;
    logic [REG_IDX_W-1:0] ridx;
    logic [XLEN-1:0]      rval;
    logic                 is_load;
    logic                 mw;
    logic                 rdback;
  } wb_t;

endpackage

FILE: design/srde_ram.sv
module srde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/srde_regfile.sv
module srde_regfile (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 rd_en,
  input  logic [srde_pkg::REG_IDX_W-1:0]       rs_addr,
  input  logic [srde_pkg::REG_IDX_W-1:0]       rt_addr,
  input  logic [srde_pkg::REG_IDX_W-1:0]       rd_addr,
  input  srde_pkg::reg_wr_t                    wr,
  output logic [srde_pkg::XLEN-1:0]            rs_val,
  output logic [srde_pkg::XLEN-1:0]            rt_val,
  output logic [srde_pkg::XLEN-1:0]            rd_val
);

  localparam int NREGS = 2 ** srde_pkg::REG_IDX_W;

  logic [srde_pkg::XLEN-1:0]      rs_q, rt_q, rd_q;
  logic [srde_pkg::REG_IDX_W-1:0] rs_idx_r, rt_idx_r, rd_idx_r;
  logic [NREGS-1:0]               vld_r;
  srde_pkg::reg_wr_t              wb3_r;
  logic                           we;

  assign we = rd_en && wr.valid;

  srde_ram #(.WIDTH(srde_pkg::XLEN), .DEPTH(NREGS)) u_rs_ram (
    .clk(clk), .wr_en(we), .wr_addr(wr.idx), .wr_data(wr.data),
    .rd_en(rd_en), .rd_addr(rs_addr), .rd_data(rs_q)
  );

  srde_ram #(.WIDTH(srde_pkg::XLEN), .DEPTH(NREGS)) u_rt_ram (
    .clk(clk), .wr_en(we), .wr_addr(wr.idx), .wr_data(wr.data),
    .rd_en(rd_en), .rd_addr(rt_addr), .rd_data(rt_q)
  );

  srde_ram #(.WIDTH(srde_pkg::XLEN), .DEPTH(NREGS)) u_rd_ram (
    .clk(clk), .wr_en(we), .wr_addr(wr.idx), .wr_data(wr.data),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_q)
  );

  // wb3_r: the write that landed on the same edge as the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      wb3_r.valid <= 1'b0;
    end else if (rd_en) begin
      wb3_r.valid <= wr.valid;
      wb3_r.idx   <= wr.idx;
      wb3_r.data  <= wr.data;
      if (wr.valid) begin
        vld_r[wr.idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rs_idx_r   <= rs_addr;
      rt_idx_r   <= rt_addr;
      rd_idx_r   <= rd_addr;
    end
  end

  function automatic logic [srde_pkg::XLEN-1:0] bypass(
    input logic [srde_pkg::REG_IDX_W-1:0] idx,
    input logic [srde_pkg::XLEN-1:0]      q,
    input srde_pkg::reg_wr_t              pend,
    input srde_pkg::reg_wr_t              last,
    input logic [NREGS-1:0]               vld
  );
    logic [srde_pkg::XLEN-1:0] v;
    if (pend.valid && pend.idx == idx) begin
      v = pend.data;
    end else if (last.valid && last.idx == idx) begin
      v = last.data;
    end else if (vld[idx]) begin
      v = q;
    end else begin
      v = '0;
    end
    return v;
  endfunction

  assign rs_val = bypass(rs_idx_r, rs_q, wr, wb3_r, vld_r);
  assign rt_val = bypass(rt_idx_r, rt_q, wr, wb3_r, vld_r);
  assign rd_val = bypass(rd_idx_r, rd_q, wr, wb3_r, vld_r);

endmodule

FILE: design/srde_exec.sv
module srde_exec #(
  parameter int DATA_MEM_DEPTH = srde_pkg::DATA_MEM_DEPTH_DEF,
  parameter int PC_WIDTH       = srde_pkg::PC_WIDTH_DEF
) (
  input  srde_pkg::in_item_t              item,
  input  logic [PC_WIDTH-1:0]             pc,
  input  logic                            halted,
  input  logic [srde_pkg::XLEN-1:0]       rs_val,
  input  logic [srde_pkg::XLEN-1:0]       rt_val,
  input  logic [srde_pkg::XLEN-1:0]       rd_val,
  output logic [PC_WIDTH-1:0]             pc_nxt,
  output srde_pkg::ex_ctl_t               ctl
);

  logic [7:0]                     op;
  logic [srde_pkg::REG_IDX_W-1:0] rd_idx, rs_idx, rt_idx;
  logic [srde_pkg::XLEN-1:0]      imm, a, b, dv, sum, res;
  logic [4:0]                     sh;
  logic [PC_WIDTH-1:0]            pc_inc;
  logic                           take, wr, sum_ok, addr_ok, invalid;

  function automatic logic [srde_pkg::XLEN-1:0] pick(
    input logic [srde_pkg::REG_IDX_W-1:0] idx,
    input logic [srde_pkg::XLEN-1:0]      imm_v,
    input logic [srde_pkg::XLEN-1:0]      reg_v
  );
    logic [srde_pkg::XLEN-1:0] v;
    if (idx == srde_pkg::REG_ZERO) begin
      v = '0;
    end else if (idx == srde_pkg::REG_IMM) begin
      v = imm_v;
    end else begin
      v = reg_v;
    end
    return v;
  endfunction

  assign op     = item.instruction[31:24];
  assign rd_idx = item.instruction[23:20];
  assign rs_idx = item.instruction[19:16];
  assign rt_idx = item.instruction[15:12];
  assign imm    = {{20{item.instruction[11]}}, item.instruction[11:0]};
  assign pc_inc = pc + 1'b1;

  assign a  = pick(rs_idx, imm, rs_val);
  assign b  = pick(rt_idx, imm, rt_val);
  // jal links r15 before the target is read
  assign dv = (op == srde_pkg::OP_JAL && rd_idx == srde_pkg::REG_LINK) ?
              32'(pc_inc) : pick(rd_idx, imm, rd_val);
  assign sh = b[4:0];

  assign sum     = a + b;
  assign sum_ok  = sum < 32'(DATA_MEM_DEPTH);
  assign addr_ok = 32'(item.mem_addr) < 32'(DATA_MEM_DEPTH);

  assign invalid = (op > srde_pkg::OP_HALT)
                || (rd_idx == srde_pkg::REG_IMM &&
                    (op <= srde_pkg::OP_SRL || op == srde_pkg::OP_BGE ||
                     op == srde_pkg::OP_SW))
                || op == srde_pkg::OP_LL || op == srde_pkg::OP_SC;

  always_comb begin
    pc_nxt       = pc;
    ctl          = '0;
    ctl.halted   = halted;
    ctl.dm_addr  = sum;
    ctl.dm_wdata = dv;
    take         = 1'b0;
    wr           = 1'b0;
    res          = '0;
    if (!halted) begin
      case (item.req_type)
        srde_pkg::REQ_MEM_WR: begin
          ctl.dm_addr  = 32'(item.mem_addr);
          ctl.dm_wdata = item.mem_data;
          ctl.dm_we    = addr_ok;
        end
        srde_pkg::REQ_MEM_RD: begin
          ctl.dm_addr = 32'(item.mem_addr);
          ctl.dm_re   = addr_ok;
          ctl.rdback  = addr_ok;
        end
        srde_pkg::REQ_EXEC: begin
          if (item.instruction == '0) begin
            ctl.nop = 1'b1;
          end else if (invalid) begin
            ctl.nop = 1'b1;
            pc_nxt  = pc_inc;
          end else begin
            pc_nxt = pc_inc;
            case (op)
              srde_pkg::OP_ADD: begin res = a + b; wr = 1'b1; end
              srde_pkg::OP_SUB: begin res = a - b; wr = 1'b1; end
              srde_pkg::OP_AND: begin res = a & b; wr = 1'b1; end
              srde_pkg::OP_OR:  begin res = a | b; wr = 1'b1; end
              srde_pkg::OP_XOR: begin res = a ^ b; wr = 1'b1; end
              srde_pkg::OP_MUL: begin res = a * b; wr = 1'b1; end
              srde_pkg::OP_SLL: begin res = a << sh; wr = 1'b1; end
              srde_pkg::OP_SRA: begin res = 32'($signed(a) >>> sh); wr = 1'b1; end
              srde_pkg::OP_SRL: begin res = a >> sh; wr = 1'b1; end
              srde_pkg::OP_BEQ: take = (a == b);
              srde_pkg::OP_BNE: take = (a != b);
              srde_pkg::OP_BLT: take = ($signed(a) < $signed(b));
              srde_pkg::OP_BGT: take = ($signed(a) > $signed(b));
              srde_pkg::OP_BLE: take = ($signed(a) <= $signed(b));
              srde_pkg::OP_BGE: take = ($signed(a) >= $signed(b));
              srde_pkg::OP_JAL: begin
                ctl.rw   = 1'b1;
                ctl.ridx = srde_pkg::REG_LINK;
                ctl.rval = 32'(pc_inc);
                take     = 1'b1;
              end
              srde_pkg::OP_LW: begin
                if (sum_ok && rd_idx >= srde_pkg::REG_FIRST_GP) begin
                  ctl.dm_re   = 1'b1;
                  ctl.rw      = 1'b1;
                  ctl.ridx    = rd_idx;
                  ctl.is_load = 1'b1;
                end
              end
              srde_pkg::OP_SW:   ctl.dm_we = sum_ok;
              srde_pkg::OP_HALT: begin
                ctl.halted = 1'b1;
                pc_nxt     = pc;
              end
              default: begin
              end
            endcase
            if (take) begin
              pc_nxt = dv[PC_WIDTH-1:0];
            end
            if (wr && rd_idx >= srde_pkg::REG_FIRST_GP) begin
              ctl.rw   = 1'b1;
              ctl.ridx = rd_idx;
              ctl.rval = res;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: design/simple_risc_decode_execute.sv
// Channel  Dir  Accept on             Payload
// in_      in   in_tvalid & in_tready  tuser: req_type; tdata: instruction, mem_addr, mem_data
// out_     out  out_tvalid & out_tready tdata: next_pc .. read_data, one item per input item
//
// One item per cycle sustained while out_tready stays high; each item is held in the execute
// register and then sits in the output register.
// Register reads issue from the register-file RAMs on acceptance; writes land when the item
// leaves the output register and are forwarded to the item in execute.
// Data memory is read or written on the edge that moves an item from execute to output.
// An output stall freezes the whole pipeline and drops in_tready.
// Reset is synchronous; no memory sweep is needed after reset.
`include "simple_risc_decode_execute_defines.svh"

module simple_risc_decode_execute #(
  parameter int DATA_MEM_DEPTH = srde_pkg::DATA_MEM_DEPTH_DEF,
  parameter int PC_WIDTH       = srde_pkg::PC_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // instruction[31:0], mem_addr[43:32], mem_data[75:44], zero[79:76]
  input  logic [srde_pkg::IN_TDATA_W-1:0]    in_tdata,
  // req_type[1:0]
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // next_pc[11:0], halted[12], was_nop[13], reg_written[14], reg_index[18:15],
  // reg_value[50:19], mem_written[51], read_data[83:52], zero[87:84]
  output logic [srde_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int DM_AW = $clog2(DATA_MEM_DEPTH);

  srde_pkg::in_item_t            in_item, ex_item_r;
  srde_pkg::ex_ctl_t             ctl;
  srde_pkg::wb_t                 s2_r;
  srde_pkg::reg_wr_t             s2w;
  logic                          adv, ex_valid_r, s2_valid_r, halt_r;
  logic [PC_WIDTH-1:0]           pc_r, pc_nxt;
  logic [srde_pkg::XLEN-1:0]     rs_val, rt_val, rd_val, dm_q, read_data;

  assign in_item.req_type    = in_tuser;
  assign in_item.instruction = in_tdata[31:0];
  assign in_item.mem_addr    = in_tdata[43:32];
  assign in_item.mem_data    = in_tdata[75:44];

  assign adv       = !s2_valid_r || out_tready;
  assign in_tready = adv;

  srde_regfile u_rf (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (adv),
    .rs_addr(in_tdata[19:16]),
    .rt_addr(in_tdata[15:12]),
    .rd_addr(in_tdata[23:20]),
    .wr     (s2w),
    .rs_val (rs_val),
    .rt_val (rt_val),
    .rd_val (rd_val)
  );

  srde_exec #(.DATA_MEM_DEPTH(DATA_MEM_DEPTH), .PC_WIDTH(PC_WIDTH)) u_exec (
    .item  (ex_item_r),
    .pc    (pc_r),
    .halted(halt_r),
    .rs_val(rs_val),
    .rt_val(rt_val),
    .rd_val(rd_val),
    .pc_nxt(pc_nxt),
    .ctl   (ctl)
  );

  srde_ram #(.WIDTH(srde_pkg::XLEN), .DEPTH(DATA_MEM_DEPTH)) u_dmem (
    .clk    (clk),
    .wr_en  (adv && ex_valid_r && ctl.dm_we),
    .wr_addr(ctl.dm_addr[DM_AW-1:0]),
    .wr_data(ctl.dm_wdata),
    .rd_en  (adv && ex_valid_r && ctl.dm_re),
    .rd_addr(ctl.dm_addr[DM_AW-1:0]),
    .rd_data(dm_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      pc_r       <= '0;
      halt_r     <= 1'b0;
    end else if (adv) begin
      ex_valid_r <= in_tvalid;
      s2_valid_r <= ex_valid_r;
      if (ex_valid_r) begin
        pc_r   <= pc_nxt;
        halt_r <= ctl.halted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ex_item_r <= in_item;
      if (ex_valid_r) begin
        s2_r.nop     <= ctl.nop;
        s2_r.rw      <= ctl.rw;
        s2_r.ridx    <= ctl.ridx;
        s2_r.rval    <= ctl.rval;
        s2_r.is_load <= ctl.is_load;
        s2_r.mw      <= ctl.dm_we;
        s2_r.rdback  <= ctl.rdback;
      end
    end
  end

  assign s2w.valid = s2_valid_r && s2_r.rw;
  assign s2w.idx   = s2_r.ridx;
  assign s2w.data  = s2_r.is_load ? dm_q : s2_r.rval;
  assign read_data = s2_r.rdback ? dm_q : '0;

  assign out_tvalid = s2_valid_r;
  assign out_tdata  = {4'b0, read_data, s2_r.mw, s2w.data, s2_r.ridx, s2_r.rw, s2_r.nop,
                       halt_r, srde_pkg::NEXT_PC_W'(pc_r)};

  `SRDE_ASSERT_NEXT(a_halt_sticky, halt_r, halt_r, "halt flag cleared")
  `SRDE_ASSERT_NEXT(a_stall_freeze, s2_valid_r && !out_tready, $stable(pc_r) && $stable(s2_r), "pipeline moved during stall")
  `SRDE_ASSERT_SAME(a_no_low_write, s2_valid_r && s2_r.rw, s2_r.ridx != srde_pkg::REG_ZERO && s2_r.ridx != srde_pkg::REG_IMM, "write to r0 or r1")
  `SRDE_ASSERT_NEXT(a_halted_inert, ex_valid_r && halt_r && adv, !s2_r.rw && !s2_r.mw && !s2_r.rdback, "item after halt had an effect")

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import srde_pkg::*;

  localparam int RAND_ITEMS   = 600;
  localparam int DRAIN_CYCLES = 8;
  localparam int WINDOW       = 64;

  // mirrors out_tdata[83:0], next_pc in the lowest bits
  typedef struct packed {
    logic [31:0] read_data;
    logic        mem_written;
    logic [31:0] reg_value;
    logic [3:0]  reg_index;
    logic        reg_written;
    logic        was_nop;
    logic        halted;
    logic [11:0] next_pc;
  } core_result_t;

  typedef struct {
    logic [1:0]   req;
    logic [31:0]  inst;
    logic [11:0]  maddr;
    logic [31:0]  mdata;
    bit           typed;
    core_result_t res;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [31:0] gpr [16];
  logic [11:0] pc_q;
  logic        halt_q;
  logic [31:0] dmem [DATA_MEM_DEPTH_DEF];
  bit          dmem_valid [DATA_MEM_DEPTH_DEF];
  logic [11:0] written_addrs [$];

  core_result_t exp_results [$];
  stim_row_t    rows [$];
  int           head_rows;
  int           errors = 0;
  int           sent = 0;
  int           idle_pct = 0;
  int           stall_pct = 0;

  simple_risc_decode_execute dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [31:0] encode(logic [7:0] op, logic [3:0] rd, logic [3:0] rs,
                                         logic [3:0] rt, logic [11:0] imm);
    return {op, rd, rs, rt, imm};
  endfunction

  function automatic core_result_t outcome(logic [11:0] npc, logic nop, logic rw,
                                           logic [3:0] ridx, logic [31:0] rval, logic mw,
                                           logic [31:0] rdata);
    core_result_t r;
    r = '0;
    r.next_pc     = npc;
    r.was_nop     = nop;
    r.reg_written = rw;
    r.reg_index   = ridx;
    r.reg_value   = rval;
    r.mem_written = mw;
    r.read_data   = rdata;
    return r;
  endfunction

  function automatic stim_row_t stim(logic [1:0] req, logic [31:0] inst, logic [11:0] maddr,
                                     logic [31:0] mdata, bit typed, core_result_t res);
    stim_row_t s;
    s.req   = req;
    s.inst  = inst;
    s.maddr = maddr;
    s.mdata = mdata;
    s.typed = typed;
    s.res   = res;
    return s;
  endfunction

  function automatic logic [31:0] src_val(logic [3:0] idx, logic [31:0] imm_x);
    if (idx == REG_ZERO) return '0;
    if (idx == REG_IMM) return imm_x;
    return gpr[idx];
  endfunction

  function automatic bit is_void_form(logic [31:0] inst);
    logic [7:0] op;
    logic [3:0] rd;
    op = inst[31:24];
    rd = inst[23:20];
    return (op > OP_HALT) || op == OP_LL || op == OP_SC ||
           (rd == REG_IMM && (op <= OP_SRL || op == OP_BGE || op == OP_SW));
  endfunction

  function automatic bit hits_unwritten(logic [1:0] req, logic [31:0] inst, logic [11:0] maddr);
    logic [31:0] imm_x;
    logic [31:0] ea;
    imm_x = {{20{inst[11]}}, inst[11:0]};
    ea    = src_val(inst[19:16], imm_x) + src_val(inst[15:12], imm_x);
    if (halt_q) return 0;
    if (req == REQ_MEM_RD) return !dmem_valid[maddr];
    return req == REQ_EXEC && inst != '0 && !is_void_form(inst) && inst[31:24] == OP_LW &&
           ea < DATA_MEM_DEPTH_DEF && !dmem_valid[ea[11:0]];
  endfunction

  task automatic store_word(input logic [11:0] addr, input logic [31:0] data);
    dmem[addr] = data;
    if (!dmem_valid[addr]) written_addrs.push_back(addr);
    dmem_valid[addr] = 1'b1;
  endtask

  task automatic core_step(input logic [1:0] req, input logic [31:0] inst,
                           input logic [11:0] maddr, input logic [31:0] mdata,
                           output core_result_t r);
    logic [7:0]  op;
    logic [3:0]  rd;
    logic [31:0] imm_x;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] ea;
    logic [31:0] res;
    logic [31:0] tgt;
    logic [4:0]  sh;
    logic [11:0] npc;
    bit          wr;
    bit          take;
    r = '0;
    if (!halt_q) begin
      if (req == REQ_MEM_WR) begin
        store_word(maddr, mdata);
        r.mem_written = 1'b1;
      end else if (req == REQ_MEM_RD) begin
        r.read_data = dmem[maddr];
      end else if (req == REQ_EXEC) begin
        op    = inst[31:24];
        rd    = inst[23:20];
        imm_x = {{20{inst[11]}}, inst[11:0]};
        a     = src_val(inst[19:16], imm_x);
        b     = src_val(inst[15:12], imm_x);
        ea    = a + b;
        sh    = b[4:0];
        wr    = 0;
        take  = 0;
        res   = '0;
        if (inst == '0) begin
          r.was_nop = 1'b1;
        end else if (is_void_form(inst)) begin
          r.was_nop = 1'b1;
          pc_q = pc_q + 12'd1;
        end else begin
          npc = pc_q + 12'd1;
          case (op)
            OP_ADD: begin res = a + b; wr = 1; end
            OP_SUB: begin res = a - b; wr = 1; end
            OP_AND: begin res = a & b; wr = 1; end
            OP_OR:  begin res = a | b; wr = 1; end
            OP_XOR: begin res = a ^ b; wr = 1; end
            OP_MUL: begin res = a * b; wr = 1; end
            OP_SLL: begin res = a << sh; wr = 1; end
            OP_SRA: begin res = $signed(a) >>> sh; wr = 1; end
            OP_SRL: begin res = a >> sh; wr = 1; end
            OP_BEQ: take = (a == b);
            OP_BNE: take = (a != b);
            OP_BLT: take = ($signed(a) < $signed(b));
            OP_BGT: take = ($signed(a) > $signed(b));
            OP_BLE: take = ($signed(a) <= $signed(b));
            OP_BGE: take = ($signed(a) >= $signed(b));
            OP_JAL: begin
              gpr[REG_LINK] = {20'd0, pc_q + 12'd1};
              r.reg_written = 1'b1;
              r.reg_index   = REG_LINK;
              r.reg_value   = gpr[REG_LINK];
              take = 1;
            end
            OP_LW: begin
              if (ea < DATA_MEM_DEPTH_DEF) begin
                res = dmem[ea[11:0]];
                wr  = 1;
              end
            end
            OP_SW: begin
              if (ea < DATA_MEM_DEPTH_DEF) begin
                store_word(ea[11:0], src_val(rd, imm_x));
                r.mem_written = 1'b1;
              end
            end
            default: begin
              halt_q = 1'b1;
              npc    = pc_q;
            end
          endcase
          if (take) begin
            tgt = src_val(rd, imm_x);
            npc = tgt[11:0];
          end
          if (wr && rd >= REG_FIRST_GP) begin
            gpr[rd]       = res;
            r.reg_written = 1'b1;
            r.reg_index   = rd;
            r.reg_value   = res;
          end
          pc_q = npc;
        end
      end
    end
    r.next_pc = pc_q;
    r.halted  = halt_q;
  endtask

  task automatic send_item(input logic [1:0] req, input logic [31:0] inst,
                           input logic [11:0] maddr, input logic [31:0] mdata,
                           input bit typed, input core_result_t typed_res);
    core_result_t r;
    case ((sent / 80) % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 46; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 46; end
      default: begin idle_pct = 9; stall_pct = 9; end
    endcase
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {4'd0, mdata, maddr, inst};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    core_step(req, inst, maddr, mdata, r);
    exp_results.push_back(typed ? typed_res : r);
    sent++;
    @(negedge clk);
  endtask

  task automatic walk_rows(input int lo, input int hi);
    for (int i = lo; i < hi; i++)
      send_item(rows[i].req, rows[i].inst, rows[i].maddr, rows[i].mdata, rows[i].typed,
                rows[i].res);
  endtask

  task automatic rand_item(output logic [1:0] req, output logic [31:0] inst,
                           output logic [11:0] maddr, output logic [31:0] mdata);
    int         kind;
    int         tries;
    logic [7:0] op;
    logic [3:0] rd;
    logic [3:0] rs;
    logic [3:0] rt;
    logic [11:0] imm;
    tries = 0;
    do begin
      kind  = $urandom_range(99);
      maddr = 12'($urandom);
      mdata = $urandom;
      rd    = 4'($urandom);
      rs    = 4'($urandom);
      rt    = 4'($urandom);
      imm   = 12'($urandom);
      op    = 8'($urandom_range(OP_SC, OP_ADD));
      if (kind >= 22 && kind < 25) op = 8'($urandom_range(255, OP_HALT + 1));
      if ((op == OP_LW || op == OP_SW) && $urandom_range(9) < 7) begin
        rs  = REG_IMM;
        rt  = REG_ZERO;
        imm = 12'($urandom_range(WINDOW - 1));
      end
      inst = encode(op, rd, rs, rt, imm);
      req  = REQ_EXEC;
      if (kind < 15) begin
        req = REQ_MEM_WR;
        if ($urandom_range(3) != 0) maddr = 12'($urandom_range(WINDOW - 1));
      end else if (kind < 22) begin
        req = REQ_MEM_RD;
        if (written_addrs.size() != 0)
          maddr = written_addrs[$urandom_range(written_addrs.size() - 1)];
      end else if (kind == 25) begin
        inst = '0;
      end
      tries++;
    end while (hits_unwritten(req, inst, maddr) && tries < 100);
    if (hits_unwritten(req, inst, maddr)) req = REQ_MEM_WR;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_mon
    core_result_t got;
    core_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[83:0];
      if (exp_results.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = exp_results.pop_front();
        check_field("next_pc", want.next_pc, got.next_pc);
        check_field("halted", want.halted, got.halted);
        check_field("was_nop", want.was_nop, got.was_nop);
        check_field("reg_written", want.reg_written, got.reg_written);
        check_field("reg_index", want.reg_index, got.reg_index);
        check_field("reg_value", want.reg_value, got.reg_value);
        check_field("mem_written", want.mem_written, got.mem_written);
        check_field("read_data", want.read_data, got.read_data);
      end
    end
  end

  initial begin
    logic [1:0]  req;
    logic [31:0] inst;
    logic [11:0] maddr;
    logic [31:0] mdata;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = REQ_EXEC;
    for (int i = 0; i < 16; i++) gpr[i] = '0;
    pc_q   = '0;
    halt_q = 1'b0;

    rows.push_back(stim(REQ_EXEC, '0, 12'h000, '0, 1, outcome(0, 1, 0, 0, 0, 0, 0)));
    rows.push_back(stim(REQ_MEM_WR, encode(OP_ADD, 2, REG_IMM, REG_ZERO, 0), 12'hFFF,
                        32'hFFFF_FFFF, 1, outcome(0, 0, 0, 0, 0, 1, 0)));
    rows.push_back(stim(REQ_MEM_RD, '0, 12'hFFF, '0, 1,
                        outcome(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF)));
    rows.push_back(stim(REQ_MEM_WR, 32'hFFFF_FFFF, 12'h000, '0, 1,
                        outcome(0, 0, 0, 0, 0, 1, 0)));
    rows.push_back(stim(REQ_MEM_RD, 32'hFFFF_FFFF, 12'h000, 32'hFFFF_FFFF, 1,
                        outcome(0, 0, 0, 0, 0, 0, 0)));
    rows.push_back(stim(REQ_EXEC, encode(OP_ADD, 2, REG_IMM, REG_ZERO, 12'h7FF), 0, 0, 1,
                        outcome(1, 0, 1, 2, 32'h0000_07FF, 0, 0)));
    rows.push_back(stim(REQ_EXEC, encode(OP_ADD, 3, REG_IMM, REG_ZERO, 12'h800), 0, 0, 1,
                        outcome(2, 0, 1, 3, 32'hFFFF_F800, 0, 0)));
    rows.push_back(stim(REQ_EXEC, encode(OP_ADD, REG_IMM, 2, 2, 0), 0, 0, 1,
                        outcome(3, 1, 0, 0, 0, 0, 0)));
    rows.push_back(stim(REQ_EXEC, 32'hFFFF_FFFF, 0, 0, 1, outcome(4, 1, 0, 0, 0, 0, 0)));
    rows.push_back(stim(REQ_EXEC, encode(OP_LL, 2, 2, 2, 0), 0, 0, 1,
                        outcome(5, 1, 0, 0, 0, 0, 0)));
    rows.push_back(stim(REQ_EXEC, encode(OP_SC, 2, 2, 2, 0), 0, 0, 1,
                        outcome(6, 1, 0, 0, 0, 0, 0)));
    rows.push_back(stim(REQ_EXEC, encode(OP_SUB, 4, 3, 2, 0), 0, 0, 0, '0));
    rows.push_back(stim(REQ_EXEC, encode(OP_AND, 5, 3, REG_IMM, 12'hFFF), 0, 0, 0, '0));
    rows.push_back(stim(REQ_EXEC, encode(OP_OR, 6, 2, 3, 0), 0, 0, 0, '0));
    rows.push_back(stim(REQ_EXEC, encode(OP_XOR, 7, 3, REG_IMM, 12'h555), 0, 0, 0, '0));
    rows.push_back(stim(REQ_EXEC, encode(OP_MUL, 8, 3, 3, 0), 0, 0, 0, '0));
    rows.push_back(stim(REQ_EXEC, encode(OP_SLL, 9, 3, REG_IMM, 12'h01F), 0, 0, 0, '0));
    rows.push_back(stim(REQ_EXEC, encode(OP_SRA, 10, 3, REG_IMM, 12'h024), 0, 0, 0, '0));
    rows.push_back(stim(REQ_EXEC, encode(OP_SRL, 11, 3, REG_IMM, 12'h024), 0, 0, 0, '0));
    rows.push_back(stim(REQ_EXEC, encode(OP_SW, 2, REG_IMM, REG_ZERO, 12'h010), 0, 0, 0, '0));
    rows.push_back(stim(REQ_EXEC, encode(OP_LW, 12, REG_IMM, REG_ZERO, 12'h010), 0, 0, 0, '0));
    rows.push_back(stim(REQ_EXEC, encode(OP_LW, REG_IMM, REG_IMM, REG_ZERO, 12'h010), 0, 0, 0,
                        '0));
    rows.push_back(stim(REQ_EXEC, encode(OP_SW, 2, 3, 3, 0), 0, 0, 0, '0));
    rows.push_back(stim(REQ_EXEC, encode(OP_BEQ, 2, 3, 3, 0), 0, 0, 0, '0));
    rows.push_back(stim(REQ_EXEC, encode(OP_BNE, REG_IMM, 2, 3, 12'h020), 0, 0, 0, '0));
    rows.push_back(stim(REQ_EXEC, encode(OP_BLT, REG_ZERO, 3, 2, 0), 0, 0, 0, '0));
    rows.push_back(stim(REQ_EXEC, encode(OP_BGT, 2, 3, 2, 0), 0, 0, 0, '0));
    rows.push_back(stim(REQ_EXEC, encode(OP_BLE, 3, 2, 2, 0), 0, 0, 0, '0));
    rows.push_back(stim(REQ_EXEC, encode(OP_BGE, REG_IMM, 2, 3, 0), 0, 0, 0, '0));
    rows.push_back(stim(REQ_EXEC, encode(OP_JAL, REG_LINK, 0, 0, 0), 0, 0, 0, '0));
    rows.push_back(stim(REQ_EXEC, encode(OP_JAL, 2, 0, 0, 0), 0, 0, 0, '0));
    head_rows = rows.size();
    rows.push_back(stim(REQ_EXEC, encode(OP_HALT, 0, 0, 0, 0), 0, 0, 0, '0));
    rows.push_back(stim(REQ_EXEC, encode(OP_ADD, 2, REG_IMM, REG_ZERO, 12'h123), 0, 0, 0, '0));
    rows.push_back(stim(REQ_MEM_WR, '0, 12'h005, 32'h1234_5678, 0, '0));
    rows.push_back(stim(REQ_MEM_RD, '0, 12'h000, '0, 0, '0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    walk_rows(0, head_rows);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      rand_item(req, inst, maddr, mdata);
      send_item(req, inst, maddr, mdata, 0, '0);
    end
    // halt last: nothing after it changes state
    walk_rows(head_rows, rows.size());
    in_tvalid <= 1'b0;

    while (exp_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/srde_pkg.sv
design/srde_ram.sv
design/srde_regfile.sv
design/srde_exec.sv
design/simple_risc_decode_execute.sv
dv/tb_top.sv
